FILE: hw/rtl/lcs_pkg.sv
package lcs_pkg;

  // field and datapath widths
  localparam int unsigned RateW  = 32;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned FracW  = 16;
  localparam int unsigned AlphaW = FracW + 1;
  localparam int unsigned QuotW  = FracW + 8;
  localparam int unsigned ProdW  = AlphaW + RateW;
  localparam int unsigned CntW   = 5;

  localparam logic [RateW-1:0] WindowReset = RateW'(10_000_000);
  localparam logic [8:0]       ExpLastIdx  = 9'd24;

  // request opcodes
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_DELAY  = 2'd1,
    OP_ACKED  = 2'd2,
    OP_UPDATE = 2'd3
  } lcs_op_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [RateW-1:0] rate_bps;
    logic [TimeW-1:0] time_us;
  } lcs_req_t;

  typedef struct packed {
    logic [RateW-1:0] capacity_bps;
    logic             blended;
  } lcs_rsp_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_TARGET,
    S_DECIDE,
    S_RANGE,
    S_DIV,
    S_INTERP,
    S_IMUL,
    S_ALPHA,
    S_BSETUP,
    S_BMUL,
    S_BLEND,
    S_DONE
  } lcs_state_e;

  // sequencer to datapath
  typedef struct packed {
    logic idle;
    logic load;
    logic target;
    logic decide;
    logic range;
    logic div;
    logic interp;
    logic imul;
    logic alpha;
    logic bsetup;
    logic bmul;
    logic blend;
    logic emit;
  } lcs_ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic blend_go;
    logic stamp_valid;
    logic sat;
    logic div_last;
    logic alpha_zero;
  } lcs_stat_t;

  // exp(-k/2) in Q1.16, zero past the last entry
  function automatic logic [AlphaW-1:0] exp_half(input logic [4:0] k);
    logic [AlphaW-1:0] v;
    unique case (k)
      5'd0:    v = AlphaW'(65536);
      5'd1:    v = AlphaW'(39750);
      5'd2:    v = AlphaW'(24109);
      5'd3:    v = AlphaW'(14623);
      5'd4:    v = AlphaW'(8869);
      5'd5:    v = AlphaW'(5380);
      5'd6:    v = AlphaW'(3263);
      5'd7:    v = AlphaW'(1979);
      5'd8:    v = AlphaW'(1200);
      5'd9:    v = AlphaW'(728);
      5'd10:   v = AlphaW'(442);
      5'd11:   v = AlphaW'(268);
      5'd12:   v = AlphaW'(162);
      5'd13:   v = AlphaW'(99);
      5'd14:   v = AlphaW'(60);
      5'd15:   v = AlphaW'(36);
      5'd16:   v = AlphaW'(22);
      5'd17:   v = AlphaW'(13);
      5'd18:   v = AlphaW'(8);
      5'd19:   v = AlphaW'(5);
      5'd20:   v = AlphaW'(3);
      5'd21:   v = AlphaW'(2);
      5'd22:   v = AlphaW'(1);
      5'd23:   v = AlphaW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/lcs_seq.sv
module lcs_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_free_i,
  input  lcs_pkg::lcs_stat_t stat_i,
  output lcs_pkg::lcs_ctl_t  ctl_o
);
  import lcs_pkg::*;

  lcs_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_TARGET;
      end
      S_TARGET: state_d = S_DECIDE;
      S_DECIDE: begin
        if (!stat_i.blend_go)        state_d = S_DONE;
        else if (stat_i.stamp_valid) state_d = S_RANGE;
        else                         state_d = S_BSETUP;
      end
      S_RANGE:  state_d = stat_i.sat ? S_BSETUP : S_DIV;
      S_DIV: begin
        if (stat_i.div_last) state_d = S_INTERP;
      end
      S_INTERP: state_d = stat_i.alpha_zero ? S_BSETUP : S_IMUL;
      S_IMUL:   state_d = S_ALPHA;
      S_ALPHA:  state_d = S_BSETUP;
      S_BSETUP: state_d = S_BMUL;
      S_BMUL:   state_d = S_BLEND;
      S_BLEND:  state_d = S_DONE;
      S_DONE: begin
        if (out_free_i) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl_o        = '0;
    ctl_o.idle   = (state_q == S_IDLE);
    ctl_o.load   = (state_q == S_IDLE) && in_valid_i;
    ctl_o.target = (state_q == S_TARGET);
    ctl_o.decide = (state_q == S_DECIDE);
    ctl_o.range  = (state_q == S_RANGE);
    ctl_o.div    = (state_q == S_DIV);
    ctl_o.interp = (state_q == S_INTERP);
    ctl_o.imul   = (state_q == S_IMUL);
    ctl_o.alpha  = (state_q == S_ALPHA);
    ctl_o.bsetup = (state_q == S_BSETUP);
    ctl_o.bmul   = (state_q == S_BMUL);
    ctl_o.blend  = (state_q == S_BLEND);
    ctl_o.emit   = (state_q == S_DONE) && out_free_i;
  end

`ifndef SYNTHESIS
  a_idle_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |=> state_q == S_IDLE || state_q == S_TARGET)
    else $error("idle left to a state other than target");
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && !out_free_i |=> state_q == S_DONE)
    else $error("done left while output register full");
`endif

endmodule

FILE: hw/rtl/lcs_dp.sv
module lcs_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lcs_pkg::lcs_ctl_t          ctl_i,
  input  lcs_pkg::lcs_req_t          req_i,
  input  logic [lcs_pkg::RateW-1:0]  win_i,
  output lcs_pkg::lcs_stat_t         stat_o,
  output logic [lcs_pkg::RateW-1:0]  cap_o,
  output logic                       blended_o
);
  import lcs_pkg::*;

  // request copy
  lcs_op_e          op_q;
  logic [RateW-1:0] rate_q;
  logic [TimeW-1:0] time_q;

  // tracker state
  logic [RateW-1:0] cap_q;
  logic [RateW-1:0] last_delay_q;
  logic             delay_seen_q;
  logic [TimeW-1:0] stamp_q;
  logic             stamp_valid_q;
  logic [RateW-1:0] acked_q;
  logic             acked_valid_q;
  logic             blended_q;

  // work registers
  logic [RateW-1:0]  target_q;
  logic [TimeW-1:0]  dt_q;
  logic [RateW-1:0]  rem_q;
  logic [QuotW-1:0]  num_q;
  logic [QuotW-1:0]  quot_q;
  logic [CntW-1:0]   cnt_q;
  logic [AlphaW-1:0] t0_q;
  logic [AlphaW-1:0] alpha_q;
  logic [AlphaW-1:0] mul_a_q;
  logic [RateW-1:0]  mul_b_q;
  logic [ProdW-1:0]  prod_q;

  logic [RateW-1:0]  win_eff;
  logic [RateW:0]    div_sh;
  logic [RateW:0]    div_diff;
  logic              div_ge;
  logic [8:0]        exp_idx;
  logic [AlphaW-1:0] exp_lo;
  logic [AlphaW-1:0] exp_hi;
  logic [ProdW-1:0]  mul_p;
  logic [ProdW-1:0]  blend_sum;
  logic              delay_drop;

  // a zero window counts as one microsecond
  assign win_eff = (win_i == '0) ? RateW'(1) : win_i;

  // restoring divide step
  assign div_sh   = {rem_q, num_q[QuotW-1]};
  assign div_ge   = div_sh >= {1'b0, win_eff};
  assign div_diff = div_sh - {1'b0, win_eff};

  // table lookup for interpolation
  assign exp_idx = quot_q[QuotW-1:FracW-1];
  assign exp_lo  = exp_half(exp_idx[4:0]);
  assign exp_hi  = exp_half(exp_idx[4:0] + 5'd1);

  // shared multiplier and blend
  assign mul_p     = {{RateW{1'b0}}, mul_a_q} * {{AlphaW{1'b0}}, mul_b_q};
  assign blend_sum = {1'b0, target_q, {FracW{1'b0}}} + ProdW'(1 << (FracW - 1)) - prod_q;

  assign delay_drop = !delay_seen_q || (rate_q < last_delay_q);

  // status to sequencer
  always_comb begin
    stat_o             = '0;
    stat_o.blend_go    = (op_q == OP_UPDATE) && acked_valid_q && (target_q > cap_q);
    stat_o.stamp_valid = stamp_valid_q;
    stat_o.sat         = dt_q >= {{(TimeW-RateW-8){1'b0}}, win_eff, 8'h00};
    stat_o.div_last    = (cnt_q == '0);
    stat_o.alpha_zero  = exp_idx >= ExpLastIdx;
  end

  assign cap_o     = cap_q;
  assign blended_o = blended_q;

  // tracker state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q         <= '0;
      last_delay_q  <= '0;
      delay_seen_q  <= 1'b0;
      stamp_q       <= '0;
      stamp_valid_q <= 1'b0;
      acked_q       <= '0;
      acked_valid_q <= 1'b0;
    end else if (ctl_i.decide) begin
      unique case (op_q)
        OP_START: begin
          if (!stamp_valid_q) cap_q <= rate_q;
        end
        OP_DELAY: begin
          if (delay_drop) begin
            if (rate_q < cap_q) cap_q <= rate_q;
            stamp_q       <= time_q;
            stamp_valid_q <= 1'b1;
          end
          last_delay_q <= rate_q;
          delay_seen_q <= 1'b1;
        end
        OP_ACKED: begin
          acked_q       <= rate_q;
          acked_valid_q <= 1'b1;
        end
        OP_UPDATE: begin
          if (acked_valid_q) begin
            stamp_q       <= time_q;
            stamp_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end else if (ctl_i.blend) begin
      cap_q <= blend_sum[RateW+FracW-1:FracW];
    end
  end

  // request copy and blend flag
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q      <= lcs_op_e'(req_i.opcode);
      rate_q    <= req_i.rate_bps;
      time_q    <= req_i.time_us;
      blended_q <= 1'b0;
    end else if (ctl_i.blend) begin
      blended_q <= 1'b1;
    end
  end

  // ratio, alpha and multiplier work registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.target) begin
      target_q <= (acked_q < rate_q) ? acked_q : rate_q;
    end
    if (ctl_i.decide) begin
      dt_q    <= (time_q >= stamp_q) ? (time_q - stamp_q) : '0;
      alpha_q <= '0;
    end
    if (ctl_i.range) begin
      rem_q  <= dt_q[RateW+7:8];
      num_q  <= {dt_q[7:0], {FracW{1'b0}}};
      quot_q <= '0;
      cnt_q  <= CntW'(QuotW - 1);
      alpha_q <= '0;
    end
    if (ctl_i.div) begin
      rem_q  <= div_ge ? div_diff[RateW-1:0] : div_sh[RateW-1:0];
      num_q  <= {num_q[QuotW-2:0], 1'b0};
      quot_q <= {quot_q[QuotW-2:0], div_ge};
      cnt_q  <= cnt_q - CntW'(1);
    end
    if (ctl_i.interp) begin
      alpha_q <= '0;
      t0_q    <= exp_lo;
      mul_a_q <= exp_lo - exp_hi;
      mul_b_q <= {{(RateW-FracW+1){1'b0}}, quot_q[FracW-2:0]};
    end
    if (ctl_i.imul || ctl_i.bmul) begin
      prod_q <= mul_p;
    end
    if (ctl_i.alpha) begin
      alpha_q <= t0_q - prod_q[AlphaW+FracW-2:FracW-1];
    end
    if (ctl_i.bsetup) begin
      mul_a_q <= alpha_q;
      mul_b_q <= target_q - cap_q;
    end
  end

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.div |-> rem_q < win_eff)
    else $error("divide remainder not below window");
  a_blend_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.blend |=> cap_q >= $past(cap_q))
    else $error("blend lowered the capacity");
`endif

endmodule

FILE: hw/rtl/link_capacity_smoother_top.sv
// Link capacity tracker with exponential smoothing.
// Input channel: in_valid_i / in_stall_o carry one rate event request
// (opcode, rate_bps, time_us). Output channel: out_valid_o / out_stall_i
// carry one result per event (capacity_bps after the event, blended flag).
// cfg_we_i / cfg_wdata_i write the smoothing window in microseconds; a zero
// window acts as one microsecond.
// The block works on one request at a time; in_stall_o is high while busy.
// Starting rate, delay estimate, acked rate and non-blending updates pass
// only through the target and decide states. A blending update with a prior
// stamp adds a restoring divider that forms dt/window one quotient bit per
// cycle, then one shared 17x32 multiplier does the table interpolation and
// the blend in two passes; a saturated ratio or a zero weight skips to the
// blend. The result is valid the cycle after the sequencer finishes.
// The output register lets a new request be accepted while a result waits.
// If the receiver stalls and the register is still full when the next result
// is ready, the sequencer holds that result until the register frees up.
// Reset clears all tracking state, empties the output and sets the window to
// ten seconds.
module link_capacity_smoother_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  lcs_pkg::lcs_req_t         in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lcs_pkg::lcs_rsp_t         out_rsp_o,
  input  logic                      cfg_we_i,
  input  logic [lcs_pkg::RateW-1:0] cfg_wdata_i
);
  import lcs_pkg::*;

  lcs_ctl_t         ctl;
  lcs_stat_t        stat;
  logic [RateW-1:0] win_q;
  logic [RateW-1:0] cap;
  logic             blended;
  logic             out_valid_q;
  lcs_rsp_t         out_rsp_q;
  logic             out_free;

  // window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WindowReset;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  lcs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  lcs_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .req_i     (in_req_i),
    .win_i     (win_q),
    .stat_o    (stat),
    .cap_o     (cap),
    .blended_o (blended)
  );

  assign in_stall_o = !ctl.idle;
  assign out_free   = !out_valid_q || !out_stall_i;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.emit) begin
      out_rsp_q.capacity_bps <= cap;
      out_rsp_q.blended      <= blended;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken without going busy");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !ctl.emit)
    else $error("result emitted over a stalled result");
`endif

endmodule

FILE: tb/tb.sv
module tb;
  import lcs_pkg::*;

  logic            clk_i;
  logic            rst_n      = 1'b0;
  logic            in_valid   = 1'b0;
  lcs_req_t        in_req     = '0;
  logic            in_stall_o;
  logic            out_valid_o;
  logic            out_stall  = 1'b0;
  lcs_rsp_t        out_rsp_o;
  logic            cfg_we     = 1'b0;
  logic [RateW-1:0] cfg_wdata = '0;

  // requests waiting to be offered, results still owed by the block
  lcs_req_t event_q[$];
  lcs_rsp_t capacity_q[$];

  int sent_cnt  = 0;
  int got_cnt   = 0;
  int fail_cnt  = 0;
  int hold_left = 0;

  // tracker image: window, capacity and the stamps
  logic [RateW-1:0] track_window = WindowReset;
  logic [RateW-1:0] cap          = '0;
  logic [RateW-1:0] last_delay   = '0;
  logic             delay_seen   = 1'b0;
  logic [TimeW-1:0] stamp        = '0;
  logic             stamp_ok     = 1'b0;
  logic [RateW-1:0] acked        = '0;
  logic             acked_ok     = 1'b0;

  logic [TimeW-1:0] clock_us   = '0;
  logic [RateW-1:0] rate_base  = 32'd1_000_000;

  // exp(-k/2) in Q1.16
  int unsigned decay_steps [25] = '{65536, 39750, 24109, 14623, 8869, 5380, 3263, 1979,
                                    1200, 728, 442, 268, 162, 99, 60, 36, 22, 13, 8, 5,
                                    3, 2, 1, 1, 0};

  link_capacity_smoother_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // elapsed time over window in Q8.16, saturating
  function automatic logic [QuotW-1:0] elapsed_ratio(logic [TimeW-1:0] dt,
                                                     logic [RateW-1:0] win);
    logic [63:0] w;
    logic [63:0] whole;
    logic [63:0] rem;
    w = (win == '0) ? 64'd1 : 64'(win);
    whole = 64'(dt) / w;
    if (whole >= 64'd256) return '1;
    rem = 64'(dt) % w;
    return QuotW'((whole << FracW) + ((rem << FracW) / w));
  endfunction

  // interpolated decay weight, Q1.16
  function automatic logic [63:0] decay_weight(logic [QuotW-1:0] q);
    logic [63:0] idx;
    logic [63:0] frac;
    logic [63:0] diff;
    idx  = 64'(q) >> (FracW - 1);
    frac = 64'(q) & ((64'd1 << (FracW - 1)) - 1);
    if (idx >= 64'd24) return 64'd0;
    diff = 64'(decay_steps[idx] - decay_steps[idx + 1]);
    return 64'(decay_steps[idx]) - ((diff * frac) >> (FracW - 1));
  endfunction

  // apply one rate event to the image and queue the capacity it yields
  task automatic track_event(input lcs_req_t r);
    lcs_rsp_t    want;
    logic [63:0] target;
    logic [63:0] alpha;
    logic [63:0] mix;
    logic [TimeW-1:0] dt;
    want.blended = 1'b0;
    case (r.opcode)
      OP_START: begin
        if (!stamp_ok) cap = r.rate_bps;
      end
      OP_DELAY: begin
        if (!delay_seen || r.rate_bps < last_delay) begin
          if (r.rate_bps < cap) cap = r.rate_bps;
          stamp    = r.time_us;
          stamp_ok = 1'b1;
        end
        last_delay = r.rate_bps;
        delay_seen = 1'b1;
      end
      OP_ACKED: begin
        acked    = r.rate_bps;
        acked_ok = 1'b1;
      end
      default: begin
        if (acked_ok) begin
          target = (acked < r.rate_bps) ? 64'(acked) : 64'(r.rate_bps);
          if (target > 64'(cap)) begin
            alpha = 64'd0;
            if (stamp_ok) begin
              dt    = (r.time_us >= stamp) ? r.time_us - stamp : '0;
              alpha = decay_weight(elapsed_ratio(dt, track_window));
            end
            mix = (alpha * 64'(cap) + ((64'd1 << FracW) - alpha) * target
                   + (64'd1 << (FracW - 1))) >> FracW;
            cap = mix[RateW-1:0];
            want.blended = 1'b1;
          end
          stamp    = r.time_us;
          stamp_ok = 1'b1;
        end
      end
    endcase
    want.capacity_bps = cap;
    capacity_q.push_back(want);
  endtask

  task automatic check_result(input lcs_rsp_t got);
    lcs_rsp_t want;
    if (capacity_q.size() == 0) begin
      if (fail_cnt < 10)
        $display("unexpected result: capacity %0d blended %0b",
                 got.capacity_bps, got.blended);
      fail_cnt++;
    end else begin
      want = capacity_q.pop_front();
      if (got.capacity_bps !== want.capacity_bps || got.blended !== want.blended) begin
        if (fail_cnt < 10)
          $display("result %0d: capacity exp %0d got %0d, blended exp %0b got %0b",
                   got_cnt, want.capacity_bps, got.capacity_bps,
                   want.blended, got.blended);
        fail_cnt++;
      end
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && !in_stall_o) begin
        track_event(in_req);
        sent_cnt++;
      end
      if (!in_valid || !in_stall_o) begin
        if (event_q.size() != 0 &&
            ((sent_cnt >= 150 && sent_cnt < 260) || $urandom_range(0, 99) >= 6)) begin
          in_valid <= 1'b1;
          in_req   <= event_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stalls and two long hold-offs
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        got_cnt++;
        check_result(out_rsp_o);
        if (got_cnt == 60 || got_cnt == 300) hold_left = 150;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !(got_cnt >= 150 && got_cnt < 260) && $urandom_range(0, 99) < 6;
      end
    end
  end

  task automatic queue_req(input lcs_op_e op, input logic [RateW-1:0] rate,
                           input logic [TimeW-1:0] t);
    lcs_req_t r;
    r.opcode   = op;
    r.rate_bps = rate;
    r.time_us  = t;
    event_q.push_back(r);
  endtask

  // wait until every request is taken and every result is back
  task automatic settle();
    do @(negedge clk_i);
    while (event_q.size() != 0 || in_valid || capacity_q.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_window(input logic [RateW-1:0] w);
    settle();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    track_window = w;
  endtask

  // mostly rates near a drifting base, timestamps stepped in window units
  task automatic random_phase(input int n);
    lcs_req_t    r;
    logic [63:0] span;
    logic [63:0] scaled;
    int          pick;
    span = (track_window == '0) ? 64'd1 : 64'(track_window);
    rate_base = $urandom_range(1000, 32'hFFFF_FFFF);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)       r.opcode = OP_START;
      else if (pick < 35) r.opcode = OP_DELAY;
      else if (pick < 55) r.opcode = OP_ACKED;
      else                r.opcode = OP_UPDATE;
      if ($urandom_range(0, 9) == 0) begin
        r.rate_bps = $urandom;
      end else begin
        scaled = (64'(rate_base) * $urandom_range(40, 160)) / 100;
        r.rate_bps = (scaled > 64'hFFFF_FFFF) ? '1 : scaled[RateW-1:0];
      end
      if ($urandom_range(0, 19) == 0) rate_base = $urandom_range(1000, 32'hFFFF_FFFF);
      pick = $urandom_range(0, 99);
      if (pick < 5)
        clock_us = TimeW'({$urandom, $urandom});
      else if (pick >= 12 && pick < 60)
        clock_us = TimeW'(64'(clock_us) + ({$urandom, $urandom} % (2 * span)));
      else if (pick >= 60)
        clock_us = TimeW'(64'(clock_us) + ({$urandom, $urandom} % (13 * span)));
      r.time_us = clock_us;
      event_q.push_back(r);
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;

    // directed: every opcode, no stamp, backwards time, saturation, extremes
    queue_req(OP_UPDATE, 32'd5, 48'd100);
    queue_req(OP_START, 32'hFFFF_FFFF, 48'd0);
    queue_req(OP_START, 32'd0, 48'd0);
    queue_req(OP_START, 32'd5000, 48'd10);
    queue_req(OP_ACKED, 32'hFFFF_FFFF, 48'd30);
    queue_req(OP_UPDATE, 32'd20000, 48'd40);
    queue_req(OP_START, 32'd7, 48'd50);
    queue_req(OP_DELAY, 32'd15000, 48'd60);
    queue_req(OP_DELAY, 32'd16000, 48'd70);
    queue_req(OP_DELAY, 32'd16000, 48'd80);
    queue_req(OP_UPDATE, 32'd30000, 48'd5_000_060);
    queue_req(OP_UPDATE, 32'd10, 48'd5_000_070);
    queue_req(OP_UPDATE, 32'd40000, 48'd100);
    queue_req(OP_UPDATE, 32'd40000, 48'd17_000_100);
    queue_req(OP_UPDATE, 32'd80000, 48'd100_000_000);
    queue_req(OP_UPDATE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_req(OP_DELAY, 32'd0, 48'hFFFF_FFFF_FFFF);
    queue_req(OP_ACKED, 32'd12345, 48'hFFFF_FFFF_FFFF);
    queue_req(OP_UPDATE, 32'd99999, 48'hFFFF_FFFF_FFFF);
    queue_req(OP_UPDATE, 32'd99999, 48'd0);
    queue_req(OP_DELAY, 32'hFFFF_FFFF, 48'd0);
    queue_req(OP_UPDATE, 32'd12345, 48'd120_000_000);
    queue_req(OP_UPDATE, 32'd20000, 48'd123_000_000);
    settle();

    // random phases over several windows, zero and the maximum among them
    clock_us = 48'd200_000_000;
    random_phase(75);
    write_window(32'd0);
    random_phase(75);
    write_window(32'd1);
    random_phase(75);
    write_window(32'hFFFF_FFFF);
    random_phase(75);
    write_window($urandom_range(1000, 5_000_000));
    random_phase(75);
    write_window(32'd250);
    random_phase(75);

    settle();
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0 && capacity_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/lcs_pkg.sv
hw/rtl/lcs_seq.sv
hw/rtl/lcs_dp.sv
hw/rtl/link_capacity_smoother_top.sv
tb/tb.sv
